// File: hdl/lisd_pkg.sv
`default_nettype none

package lisd_pkg;

  // Fixed field widths
  localparam int unsigned NOW_W  = 32;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 16;

  // Default width of the internal time arithmetic
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_ACTIVE_LOW = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_DEBOUNCE   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_SETTLE     = 2'd2;

  // Configuration reset values
  localparam logic [WIN_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [WIN_W-1:0] SETTLE_RST   = 16'd100;

  // Input word operation codes
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_POWER_ON = 1'b1;

  typedef struct packed {
    logic             op;
    logic [NOW_W-1:0] now_ms;
    logic             raw_level;
  } in_word_t;

  typedef struct packed {
    logic valid_res;
    logic present;
    logic raw_now;
  } out_word_t;

  typedef struct packed {
    logic             active_low;
    logic [WIN_W-1:0] debounce_window_ms;
    logic [WIN_W-1:0] settle_window_ms;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/level_input_settle_debounce.sv
`default_nettype none

// Level-input debouncer with power-on settle time. Each input word is a
// sample (timestamp in ms plus raw level) or a power-on notice; every word
// yields exactly one result word with valid_res, present and raw_now.
// The block takes one word per cycle while out_ready keeps up: a word is held in
// the input register, where a single pass of compare/subtract logic against
// the mode and timing registers updates the state, and the result is then
// registered in the output register. A held-off result holds the input stage
// behind it. in_ready stays high while the input register is empty or can
// move on, so a new word is taken while a result waits for out_ready
// only if the input register is empty.
// Time differences are taken modulo 2^TIME_WIDTH; a window of zero elapses
// at once. Write the cfg_ registers only while the block is idle.

module level_input_settle_debounce #(
  parameter int unsigned TIME_WIDTH = lisd_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire lisd_pkg::in_word_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output lisd_pkg::out_word_t               out_data,
  input  wire logic                         cfg_we,
  input  wire logic [lisd_pkg::CFG_AW-1:0]  cfg_index,
  input  wire logic [lisd_pkg::CFG_DW-1:0]  cfg_wdata
);

  lisd_pkg::cfg_t      cfg_r;
  lisd_pkg::in_word_t  s1_word_r;
  logic                s1_valid_r;
  lisd_pkg::out_word_t out_word_r;
  logic                out_valid_r;
  lisd_pkg::out_word_t core_res;
  logic                s1_adv;

  // Configuration registers: plain write, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low         <= 1'b0;
      cfg_r.debounce_window_ms <= lisd_pkg::DEBOUNCE_RST;
      cfg_r.settle_window_ms   <= lisd_pkg::SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lisd_pkg::CFG_ACTIVE_LOW: cfg_r.active_low         <= cfg_wdata[0];
        lisd_pkg::CFG_DEBOUNCE:   cfg_r.debounce_window_ms <= cfg_wdata;
        lisd_pkg::CFG_SETTLE:     cfg_r.settle_window_ms   <= cfg_wdata;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Advance the input stage whenever the output register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Hold the word payload; no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_data;
    end
  end

  lisd_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .word  (s1_word_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // A word in the input stage moves on as soon as the result register frees
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |-> s1_adv)
    else $error("input stage stalled with empty result register");

  // Every advance produces a result word on the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced word produced no result");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !s1_adv)
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// File: hdl/lisd_core.sv
`default_nettype none

module lisd_core #(
  parameter int unsigned TIME_WIDTH = lisd_pkg::TIME_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire lisd_pkg::in_word_t  word,
  input  wire lisd_pkg::cfg_t      cfg,
  output lisd_pkg::out_word_t      res
);

  localparam logic [1:0] MODE_SETTLING = 2'd0;
  localparam logic [1:0] MODE_WARMUP   = 2'd1;
  localparam logic [1:0] MODE_TRACKING = 2'd2;

  logic [1:0]            mode_r, mode_nxt;
  logic                  settle_started_r, settle_started_nxt;
  logic [TIME_WIDTH-1:0] settle_start_r, settle_start_nxt;
  logic                  cand_r, cand_nxt;
  logic [TIME_WIDTH-1:0] win_start_r, win_start_nxt;
  logic                  stable_r, stable_nxt;
  logic                  last_raw_r, last_raw_nxt;

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] settle_base;
  logic                  settle_done;
  logic                  debounce_done;

  assign now = TIME_WIDTH'(word.now_ms);

  // Settle window counts from this sample if it is the first one
  assign settle_base = settle_started_r ? settle_start_r : now;
  assign settle_done = TIME_WIDTH'(now - settle_base) >=
                       TIME_WIDTH'(cfg.settle_window_ms);
  assign debounce_done = TIME_WIDTH'(now - win_start_r) >=
                         TIME_WIDTH'(cfg.debounce_window_ms);

  always_comb begin
    mode_nxt           = mode_r;
    settle_started_nxt = settle_started_r;
    settle_start_nxt   = settle_start_r;
    cand_nxt           = cand_r;
    win_start_nxt      = win_start_r;
    stable_nxt         = stable_r;
    last_raw_nxt       = last_raw_r;
    if (word.op == lisd_pkg::OP_POWER_ON) begin
      mode_nxt           = MODE_SETTLING;
      settle_started_nxt = 1'b0;
    end else begin
      last_raw_nxt = word.raw_level;
      unique case (mode_r)
        MODE_WARMUP: begin
          if (word.raw_level != cand_r) begin
            cand_nxt      = word.raw_level;
            win_start_nxt = now;
          end else if (debounce_done) begin
            stable_nxt = cand_r;
            mode_nxt   = MODE_TRACKING;
          end
        end
        MODE_TRACKING: begin
          if (word.raw_level != cand_r) begin
            cand_nxt      = word.raw_level;
            win_start_nxt = now;
          end else if (cand_r != stable_r && debounce_done) begin
            stable_nxt = cand_r;
          end
        end
        default: begin
          // Settling, and the unused code behaves the same
          mode_nxt           = MODE_SETTLING;
          settle_started_nxt = 1'b1;
          settle_start_nxt   = settle_base;
          if (settle_done) begin
            mode_nxt      = MODE_WARMUP;
            cand_nxt      = word.raw_level;
            win_start_nxt = now;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= MODE_SETTLING;
      settle_started_r <= 1'b0;
      settle_start_r   <= '0;
      cand_r           <= 1'b0;
      win_start_r      <= '0;
      stable_r         <= 1'b0;
      last_raw_r       <= 1'b0;
    end else if (adv) begin
      mode_r           <= mode_nxt;
      settle_started_r <= settle_started_nxt;
      settle_start_r   <= settle_start_nxt;
      cand_r           <= cand_nxt;
      win_start_r      <= win_start_nxt;
      stable_r         <= stable_nxt;
      last_raw_r       <= last_raw_nxt;
    end
  end

  assign res.valid_res = (mode_nxt == MODE_TRACKING);
  assign res.present   = stable_nxt ^ cfg.active_low;
  assign res.raw_now   = last_raw_nxt;

  // Warm-up and tracking are only reachable through a started settle window
  a_started: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_SETTLING) |-> settle_started_r)
    else $error("left settling without a settle window");

  // A power-on notice always drops back to settling
  a_power_on: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && word.op == lisd_pkg::OP_POWER_ON) |=>
      (mode_r == MODE_SETTLING && !settle_started_r))
    else $error("power-on notice did not re-arm settling");

  // Stable level moves only to the candidate
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stable_nxt != stable_r) |-> (stable_nxt == cand_r))
    else $error("stable level changed to a non-candidate value");

  // Tracking is never entered straight from settling
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mode_r == MODE_SETTLING) |-> (mode_nxt != MODE_TRACKING))
    else $error("skipped warm-up");

endmodule

`default_nettype wire
